[sv/gol_pkg.sv]
// Shared types, matrices and bit helpers for the extended Golay (24,12) codec.
// No dependencies; every other file imports this package.
package gol_pkg;

  localparam int unsigned WORD_W = 12;
  localparam int unsigned CODE_W = 24;
  localparam int unsigned CNT_W  = 3;
  localparam int unsigned POP_W  = 4;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [CODE_W-1:0] code_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [POP_W-1:0]  pop_t;

  // Operation codes
  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  // Error count reported when no pattern of weight three or less fits
  localparam cnt_t  ERR_UNCORR = 3'd4;
  localparam word_t FIX_ALL    = 12'hFFF;

  // Parity generator rows; row 0 goes with data bit 11
  localparam word_t GEN_ROWS [WORD_W] = '{
    12'hC75, 12'h63B, 12'hF68, 12'h7B4, 12'h3DA, 12'hD99,
    12'h6CD, 12'h367, 12'hDC6, 12'hA97, 12'h93E, 12'h8EB};

  // Parity check rows; row 0 goes with parity bit 11
  localparam word_t CHK_ROWS [WORD_W] = '{
    12'hA4F, 12'hF68, 12'h7B4, 12'h3DA, 12'h1ED, 12'hAB9,
    12'hF13, 12'hDC6, 12'h6E3, 12'h93E, 12'h49F, 12'hC75};

  // Stage 1 -> stage 2: parity (encode) or syndrome (decode) in mix
  typedef struct packed {
    logic  cmd;
    word_t hi;
    word_t mix;
  } gol_s1_t;

  // Stage 2 -> stage 3: adds second syndrome and the partial correction
  typedef struct packed {
    logic  cmd;
    word_t hi;
    word_t mix;
    word_t s2;
    logic  hit;
    word_t fix;
    cnt_t  cnt;
  } gol_s2_t;

  // XOR of generator rows picked by sel, MSB first
  function automatic word_t gen_mix(input word_t sel);
    word_t acc;
    acc = '0;
    for (int r = 0; r < WORD_W; r++) begin
      if (sel[WORD_W-1-r]) acc = acc ^ GEN_ROWS[r];
    end
    return acc;
  endfunction

  // XOR of check rows picked by sel, MSB first
  function automatic word_t chk_mix(input word_t sel);
    word_t acc;
    acc = '0;
    for (int r = 0; r < WORD_W; r++) begin
      if (sel[WORD_W-1-r]) acc = acc ^ CHK_ROWS[r];
    end
    return acc;
  endfunction

  // Population count of a word
  function automatic pop_t pop12(input word_t v);
    pop_t n;
    n = '0;
    for (int b = 0; b < WORD_W; b++) begin
      n = n + pop_t'(v[b]);
    end
    return n;
  endfunction

endpackage

[sv/gol_if.sv]
// Valid/ready channel interfaces for the Golay codec input and result beats.
// Depends on gol_pkg.
interface gol_in_if;
  import gol_pkg::*;
  logic  valid;
  logic  ready;
  logic  cmd;
  word_t data_in;
  code_t codeword_in;

  modport source (output valid, cmd, data_in, codeword_in, input ready);
  modport sink   (input valid, cmd, data_in, codeword_in, output ready);
endinterface

interface gol_out_if;
  import gol_pkg::*;
  logic  valid;
  logic  ready;
  code_t codeword_out;
  word_t data_out;
  cnt_t  error_count;

  modport source (output valid, codeword_out, data_out, error_count, input ready);
  modport sink   (input valid, codeword_out, data_out, error_count, output ready);
endinterface

[sv/gol_syn.sv]
// Stage 1: parity generation for encode, first syndrome for decode.
// Depends on gol_pkg and gol_in_if.
module gol_syn import gol_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  gol_in_if.sink      in_ch,
  output logic        vld_o,
  output gol_s1_t     pay_o,
  input  logic        rdy_i
);

  logic    vld_r;
  gol_s1_t pay_r;
  gol_s1_t pay_nxt;
  logic    adv;

  // Stage moves when empty or when downstream takes its beat
  assign adv         = !vld_r || rdy_i;
  assign in_ch.ready = adv;

  // Encode: data plus parity; decode: syndrome of received word
  always_comb begin
    pay_nxt.cmd = in_ch.cmd;
    if (in_ch.cmd == CMD_ENCODE) begin
      pay_nxt.hi  = in_ch.data_in;
      pay_nxt.mix = gen_mix(in_ch.data_in);
    end else begin
      pay_nxt.hi  = in_ch.codeword_in[CODE_W-1:WORD_W];
      pay_nxt.mix = chk_mix(in_ch.codeword_in[WORD_W-1:0])
                    ^ in_ch.codeword_in[CODE_W-1:WORD_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_ch.valid) begin
      pay_r <= pay_nxt;
    end
  end

  assign vld_o = vld_r;
  assign pay_o = pay_r;

endmodule

[sv/gol_locate.sv]
// Stage 2: error search in the syndrome domain (parity half has at most one
// error) and the second syndrome for the data-half search. Depends on gol_pkg.
module gol_locate import gol_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    vld_i,
  input  gol_s1_t pay_i,
  output logic    rdy_o,
  output logic    vld_o,
  output gol_s2_t pay_o,
  input  logic    rdy_i
);

  logic    vld_r;
  gol_s2_t pay_r;
  gol_s2_t pay_nxt;
  logic    adv;
  pop_t    syn_pop;
  word_t   cand;
  pop_t    cand_pop;

  assign adv   = !vld_r || rdy_i;
  assign rdy_o = adv;

  // Syndrome of low weight: error in data half only.
  // Else try each single parity-bit error with up to two data errors.
  always_comb begin
    pay_nxt.cmd = pay_i.cmd;
    pay_nxt.hi  = pay_i.hi;
    pay_nxt.mix = pay_i.mix;
    pay_nxt.s2  = gen_mix(pay_i.mix);
    pay_nxt.hit = 1'b0;
    pay_nxt.fix = '0;
    pay_nxt.cnt = '0;
    syn_pop     = pop12(pay_i.mix);
    cand        = '0;
    cand_pop    = '0;
    if (syn_pop <= pop_t'(3)) begin
      pay_nxt.hit = 1'b1;
      pay_nxt.fix = pay_i.mix;
      pay_nxt.cnt = syn_pop[CNT_W-1:0];
    end else begin
      for (int r = 0; r < WORD_W; r++) begin
        cand     = pay_i.mix ^ CHK_ROWS[r];
        cand_pop = pop12(cand);
        if (cand_pop <= pop_t'(2)) begin
          pay_nxt.hit = 1'b1;
          pay_nxt.fix = cand;
          pay_nxt.cnt = cand_pop[CNT_W-1:0] + cnt_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vld_i) begin
      pay_r <= pay_nxt;
    end
  end

  assign vld_o = vld_r;
  assign pay_o = pay_r;

endmodule

[sv/gol_resolve.sv]
// Stage 3: error search in the second syndrome domain, final correction and
// the result register. Depends on gol_pkg and gol_out_if.
module gol_resolve import gol_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      vld_i,
  input  gol_s2_t   pay_i,
  output logic      rdy_o,
  gol_out_if.source out_ch
);

  logic  vld_r;
  code_t codeword_r;
  word_t data_r;
  cnt_t  count_r;
  code_t codeword_nxt;
  word_t data_nxt;
  cnt_t  count_nxt;
  logic  adv;
  word_t fix;
  cnt_t  cnt;
  pop_t  s2_pop;
  word_t cand;
  pop_t  cand_pop;

  assign adv   = !vld_r || out_ch.ready;
  assign rdy_o = adv;

  // Stage 2 hit kept; else parity half only (low-weight second syndrome), or
  // one data error, up to two parity errors; nothing fits means uncorrectable.
  always_comb begin
    fix      = FIX_ALL;
    cnt      = ERR_UNCORR;
    s2_pop   = pop12(pay_i.s2);
    cand     = '0;
    cand_pop = '0;
    if (pay_i.hit) begin
      fix = pay_i.fix;
      cnt = pay_i.cnt;
    end else if (s2_pop <= pop_t'(3)) begin
      fix = '0;
      cnt = s2_pop[CNT_W-1:0];
    end else begin
      for (int r = 0; r < WORD_W; r++) begin
        cand     = pay_i.s2 ^ GEN_ROWS[r];
        cand_pop = pop12(cand);
        if (cand_pop <= pop_t'(2)) begin
          fix              = '0;
          fix[WORD_W-1-r]  = 1'b1;
          cnt              = cand_pop[CNT_W-1:0] + cnt_t'(1);
        end
      end
    end
  end

  // Result fields by operation
  always_comb begin
    if (pay_i.cmd == CMD_ENCODE) begin
      codeword_nxt = {pay_i.hi, pay_i.mix};
      data_nxt     = '0;
      count_nxt    = '0;
    end else begin
      codeword_nxt = '0;
      data_nxt     = pay_i.hi ^ fix;
      count_nxt    = cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vld_i) begin
      codeword_r <= codeword_nxt;
      data_r     <= data_nxt;
      count_r    <= count_nxt;
    end
  end

  assign out_ch.valid        = vld_r;
  assign out_ch.codeword_out = codeword_r;
  assign out_ch.data_out     = data_r;
  assign out_ch.error_count  = count_r;

endmodule

[sv/golay_24_12_codec.sv]
// Extended Golay (24,12) encoder/decoder, three register stages.
// A beat passes the syn, locate and resolve registers in that order.
// Throughput: one beat per cycle; a stalled output holds and fills the
// stages behind it, and an empty stage still takes a beat while it stalls.
// Reset (synchronous, rst_n low) clears all stage valid bits; no tables.
// Depends on gol_pkg, gol_if, gol_syn, gol_locate, gol_resolve.
module golay_24_12_codec import gol_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  gol_in_if.sink    in_ch,
  gol_out_if.source out_ch
);

  logic    s1_vld;
  logic    s1_rdy;
  gol_s1_t s1_pay;
  logic    s2_vld;
  logic    s2_rdy;
  gol_s2_t s2_pay;

  // Parity / first syndrome
  gol_syn u_syn (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .vld_o (s1_vld),
    .pay_o (s1_pay),
    .rdy_i (s1_rdy)
  );

  // Parity-half search, second syndrome
  gol_locate u_locate (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (s1_vld),
    .pay_i (s1_pay),
    .rdy_o (s1_rdy),
    .vld_o (s2_vld),
    .pay_o (s2_pay),
    .rdy_i (s2_rdy)
  );

  // Data-half search, correction, result register
  gol_resolve u_resolve (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (s2_vld),
    .pay_i  (s2_pay),
    .rdy_o  (s2_rdy),
    .out_ch (out_ch)
  );

endmodule

[sv/gol_chk.sv]
// Port-level checks for the Golay codec, bound to golay_24_12_codec.
// Depends on gol_pkg.
module gol_chk import gol_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input code_t codeword_out,
  input word_t data_out,
  input cnt_t  error_count
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // An empty output stage never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  // Decode results carry no codeword, count never beyond uncorrectable
  a_decode_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && error_count != '0 |-> codeword_out == '0 && error_count <= ERR_UNCORR)
    else $error("bad decode result fields");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(codeword_out)
      && $stable(data_out) && $stable(error_count))
    else $error("result changed while stalled");

endmodule

bind golay_24_12_codec gol_chk u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .codeword_out (out_ch.codeword_out),
  .data_out     (out_ch.data_out),
  .error_count  (out_ch.error_count)
);
